/* hdl/assert_macros.svh */
// Assertion macros for the RTL files of the positional array list; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that a condition holds in the same cycle as its trigger.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/pal_pkg.sv */
// Shared types and constants for the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int MAX_RESULTS  = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int ACT_W        = 3;
    localparam int ST_W         = 3;

    // Request actions
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DUMP   = 3'd5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_COMPARE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

endpackage

/* hdl/pal_cell.sv */
// One storage cell of the list chain: holds an entry, shifts with its neighbors.
`timescale 1ns / 1ps

module pal_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 6
) (
    input  logic                              clk,
    input  pal_pkg::cell_cmd_t                cmd,
    input  logic [IW-1:0]                     key,
    input  logic signed [pal_pkg::DATA_W-1:0] prev_data,
    input  logic signed [pal_pkg::DATA_W-1:0] next_data,
    output logic signed [pal_pkg::DATA_W-1:0] data,
    output logic                              match
);

    localparam logic [IW-1:0] SLOT = IW'(INDEX);

    logic signed [pal_pkg::DATA_W-1:0] data_reg;
    logic signed [pal_pkg::DATA_W-1:0] data_next;
    logic                              match_reg;
    logic                              match_next;

    // Pick the new entry: shift up on insert, shift down on delete; update the match flag on compare
    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        unique case (cmd.op)
            pal_pkg::CELL_INSERT:
            begin
                if (SLOT > key)
                    data_next = prev_data;
                else if (SLOT == key)
                    data_next = cmd.value;
            end
            pal_pkg::CELL_DELETE:
            begin
                if (SLOT >= key)
                    data_next = next_data;
            end
            pal_pkg::CELL_COMPARE:
            begin
                match_next = (data_reg == cmd.value);
            end
            default:
            begin
                data_next  = data_reg;
                match_next = match_reg;
            end
        endcase
    end

    // Hold entry and match flag
    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

/* hdl/positional_array_list_top.sv */
// Top level of the positional array list: request decode, cell chain, scan and result port.
// Append, insert, delete, get, undefined: result in the cycle after the request, one per cycle.
// Find: every cell compares its entry with the value, then the cells' match flags are scanned
//   one per cycle from the head until the first match or the tail; busy until the result issues.
// Dump of n entries: results issue back to back in list order, last marks the final one; results never wait.
// Reset clears length, scan state and result registers; entries are undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module positional_array_list_top #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pal_pkg::ACT_W-1:0]         action,
    input  logic [pal_pkg::POS_W-1:0]         position,
    input  logic signed [pal_pkg::DATA_W-1:0] value,
    output logic                              strobe,
    output logic [pal_pkg::ST_W-1:0]          status,
    output logic signed [pal_pkg::DATA_W-1:0] data_out,
    output logic [pal_pkg::POS_W-1:0]         found_position,
    output logic [pal_pkg::POS_W-1:0]         count,
    output logic                              last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > pal_pkg::POS_W) ? LW : pal_pkg::POS_W) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] MAXR_C = CW'(pal_pkg::MAX_RESULTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_DUMP
    } state_t;

    state_t                            state_reg;
    logic [IW-1:0]                     idx_reg;
    logic [LW-1:0]                     dump_n_reg;
    logic [LW-1:0]                     len_reg;
    logic                              strobe_reg;
    logic [pal_pkg::ST_W-1:0]          status_reg;
    logic signed [pal_pkg::DATA_W-1:0] data_reg;
    logic [pal_pkg::POS_W-1:0]         fpos_reg;
    logic                              last_reg;

    pal_pkg::cell_cmd_t                cmd;
    logic [IW-1:0]                     key;
    logic signed [pal_pkg::DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]               match_vec;

    logic                              accept;
    logic                              single_req;
    logic [CW-1:0]                     pos_c;
    logic [CW-1:0]                     len_c;
    logic                              full;
    logic                              ins_bad;
    logic                              rd_bad;
    logic [IW-1:0]                     pidx;
    logic [IW-1:0]                     rd_idx;
    logic signed [pal_pkg::DATA_W-1:0] rd_data;
    logic                              scan_end;
    logic [LW-1:0]                     dump_n;

    // Decode the request against the current length
    always_comb
    begin
        accept     = start && (state_reg == S_IDLE);
        single_req = accept && (action != pal_pkg::ACT_FIND) && (action != pal_pkg::ACT_DUMP);
        pos_c      = CW'(position);
        len_c      = CW'(len_reg);
        full       = (len_c >= CAP_C);
        ins_bad    = (pos_c == '0) || (pos_c > len_c + CW'(1));
        rd_bad     = (pos_c == '0) || (pos_c > len_c);
        pidx       = IW'(position - pal_pkg::POS_W'(1));
        rd_idx     = (state_reg == S_IDLE) ? pidx : idx_reg;
        rd_data    = cell_data[rd_idx];
        scan_end   = ((LW'(idx_reg) + LW'(1)) ==
                      ((state_reg == S_DUMP) ? dump_n_reg : len_reg));
        dump_n     = (len_c > MAXR_C) ? LW'(MAXR_C) : len_reg;
    end

    // Build the chain command for this cycle
    always_comb
    begin
        cmd.op    = pal_pkg::CELL_HOLD;
        cmd.value = value;
        key       = pidx;
        if (accept)
        begin
            unique case (action)
                pal_pkg::ACT_APPEND:
                begin
                    if (!full)
                    begin
                        cmd.op = pal_pkg::CELL_INSERT;
                        key    = IW'(len_reg);
                    end
                end
                pal_pkg::ACT_INSERT:
                begin
                    if (!full && !ins_bad)
                        cmd.op = pal_pkg::CELL_INSERT;
                end
                pal_pkg::ACT_DELETE:
                begin
                    if (len_reg != '0 && !rd_bad)
                        cmd.op = pal_pkg::CELL_DELETE;
                end
                pal_pkg::ACT_FIND:
                begin
                    cmd.op = pal_pkg::CELL_COMPARE;
                end
                default:
                begin
                    cmd.op = pal_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    // Chain of cells, each fed by its neighbors
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [pal_pkg::DATA_W-1:0] prev_d;
        logic signed [pal_pkg::DATA_W-1:0] next_d;

        if (g == 0)
        begin : g_head
            assign prev_d = '0;
        end
        else
        begin : g_body
            assign prev_d = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign next_d = cell_data[g];
        end
        else
        begin : g_inner
            assign next_d = cell_data[g+1];
        end

        pal_cell #(
            .INDEX (g),
            .IW    (IW)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .key       (key),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[g]),
            .match     (match_vec[g])
        );
    end

    // Hold state, length and the registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            dump_n_reg <= '0;
            len_reg    <= '0;
            strobe_reg <= 1'b0;
            status_reg <= pal_pkg::ST_OK;
            data_reg   <= '0;
            fpos_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        strobe_reg <= 1'b1;
                        last_reg   <= 1'b1;
                        status_reg <= pal_pkg::ST_OK;
                        data_reg   <= '0;
                        fpos_reg   <= '0;
                        idx_reg    <= '0;
                        unique case (action)
                            pal_pkg::ACT_APPEND:
                            begin
                                if (full)
                                    status_reg <= pal_pkg::ST_FULL;
                                else
                                    len_reg <= len_reg + LW'(1);
                            end
                            pal_pkg::ACT_INSERT:
                            begin
                                if (full)
                                    status_reg <= pal_pkg::ST_FULL;
                                else if (ins_bad)
                                    status_reg <= pal_pkg::ST_BADPOS;
                                else
                                    len_reg <= len_reg + LW'(1);
                            end
                            pal_pkg::ACT_DELETE:
                            begin
                                if (len_reg == '0)
                                    status_reg <= pal_pkg::ST_EMPTY;
                                else if (rd_bad)
                                    status_reg <= pal_pkg::ST_BADPOS;
                                else
                                begin
                                    data_reg <= rd_data;
                                    len_reg  <= len_reg - LW'(1);
                                end
                            end
                            pal_pkg::ACT_FIND:
                            begin
                                if (len_reg == '0)
                                    status_reg <= pal_pkg::ST_EMPTY;
                                else
                                begin
                                    strobe_reg <= 1'b0;
                                    state_reg  <= S_FIND;
                                end
                            end
                            pal_pkg::ACT_GET:
                            begin
                                if (rd_bad)
                                    status_reg <= pal_pkg::ST_BADPOS;
                                else
                                    data_reg <= rd_data;
                            end
                            pal_pkg::ACT_DUMP:
                            begin
                                if (len_reg == '0)
                                    status_reg <= pal_pkg::ST_EMPTY;
                                else
                                begin
                                    strobe_reg <= 1'b0;
                                    dump_n_reg <= dump_n;
                                    state_reg  <= S_DUMP;
                                end
                            end
                            default:
                            begin
                                status_reg <= pal_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_FIND:
                begin
                    // Advance one cell per cycle until a match or the tail
                    if (match_vec[idx_reg])
                    begin
                        strobe_reg <= 1'b1;
                        last_reg   <= 1'b1;
                        status_reg <= pal_pkg::ST_OK;
                        data_reg   <= '0;
                        fpos_reg   <= pal_pkg::POS_W'({1'b0, idx_reg} + (IW + 1)'(1));
                        state_reg  <= S_IDLE;
                    end
                    else if (scan_end)
                    begin
                        strobe_reg <= 1'b1;
                        last_reg   <= 1'b1;
                        status_reg <= pal_pkg::ST_NOTFOUND;
                        data_reg   <= '0;
                        fpos_reg   <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                S_DUMP:
                begin
                    // Emit one entry per cycle, mark the final one
                    strobe_reg <= 1'b1;
                    last_reg   <= scan_end;
                    status_reg <= pal_pkg::ST_OK;
                    data_reg   <= rd_data;
                    fpos_reg   <= '0;
                    idx_reg    <= idx_reg + IW'(1);
                    if (scan_end)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign strobe         = strobe_reg;
    assign status         = status_reg;
    assign data_out       = data_reg;
    assign found_position = fpos_reg;
    assign count          = pal_pkg::POS_W'(len_reg);
    assign last           = last_reg;

    // Length never runs past the chain
    `ASSERT_ALWAYS(a_len_bound, LW'(len_reg) <= LW'(CAPACITY), "list length exceeds capacity")
    // Single-result requests answer in the next cycle
    `ASSERT_NEXT(a_single_next, single_req, strobe && last, "single-result request not answered")
    // A dump that is not finished keeps the block busy
    `ASSERT_SAME(a_dump_busy, strobe && !last, busy, "unfinished dump while not busy")

endmodule

/* tb/sv/tb.sv */
// Testbench for the positional array list: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int LIST_CAP      = pal_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = LIST_CAP + 8;
    localparam int MIX_REQUESTS  = 100;
    localparam int MAX_REPORTS   = 10;

    // Action codes the block does not define; it answers them with a plain ok
    localparam logic [pal_pkg::ACT_W-1:0] ACT_UNDEF_LO = 3'd6;
    localparam logic [pal_pkg::ACT_W-1:0] ACT_UNDEF_HI = 3'd7;

    localparam logic [pal_pkg::DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [pal_pkg::DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [pal_pkg::ST_W-1:0]   status;
        logic [pal_pkg::DATA_W-1:0] data;
        logic [pal_pkg::POS_W-1:0]  fpos;
        logic [pal_pkg::POS_W-1:0]  cnt;
        logic                       last;
    } list_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [pal_pkg::ACT_W-1:0]         action;
    logic [pal_pkg::POS_W-1:0]         position;
    logic signed [pal_pkg::DATA_W-1:0] value;
    logic                              strobe;
    logic [pal_pkg::ST_W-1:0]          status;
    logic signed [pal_pkg::DATA_W-1:0] data_out;
    logic [pal_pkg::POS_W-1:0]         found_position;
    logic [pal_pkg::POS_W-1:0]         count;
    logic                              last;

    // Shadow copy of the list, updated as each request is accepted
    logic [pal_pkg::DATA_W-1:0] shadow_entries [LIST_CAP];
    int                         shadow_len = 0;
    list_result_t               expected_results [$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    bit sender_gaps = 1'b1;

    positional_array_list_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .position       (position),
        .value          (value),
        .strobe         (strobe),
        .status         (status),
        .data_out       (data_out),
        .found_position (found_position),
        .count          (count),
        .last           (last)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void push_result(logic [pal_pkg::ST_W-1:0] st,
                                        logic [pal_pkg::DATA_W-1:0] data,
                                        logic [pal_pkg::POS_W-1:0] fpos, logic lst);
        list_result_t r;
        r.status = st;
        r.data   = data;
        r.fpos   = fpos;
        r.cnt    = pal_pkg::POS_W'(shadow_len);
        r.last   = lst;
        expected_results.push_back(r);
    endfunction

    // Apply one request to the shadow list and queue the results it should produce
    function automatic void predict_list_op(logic [pal_pkg::ACT_W-1:0] act,
                                            logic [pal_pkg::POS_W-1:0] pos,
                                            logic [pal_pkg::DATA_W-1:0] val);
        int p;
        int i;
        int hit;
        logic [pal_pkg::DATA_W-1:0] removed;
        p   = int'(pos);
        hit = 0;
        case (act)
            pal_pkg::ACT_APPEND:
            begin
                if (shadow_len >= LIST_CAP)
                    push_result(pal_pkg::ST_FULL, '0, '0, 1'b1);
                else
                begin
                    shadow_entries[shadow_len] = val;
                    shadow_len++;
                    push_result(pal_pkg::ST_OK, '0, '0, 1'b1);
                end
            end
            pal_pkg::ACT_INSERT:
            begin
                // Full wins over a bad position
                if (shadow_len >= LIST_CAP)
                    push_result(pal_pkg::ST_FULL, '0, '0, 1'b1);
                else if (p < 1 || p > shadow_len + 1)
                    push_result(pal_pkg::ST_BADPOS, '0, '0, 1'b1);
                else
                begin
                    for (i = shadow_len; i >= p; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[p-1] = val;
                    shadow_len++;
                    push_result(pal_pkg::ST_OK, '0, '0, 1'b1);
                end
            end
            pal_pkg::ACT_DELETE:
            begin
                if (shadow_len == 0)
                    push_result(pal_pkg::ST_EMPTY, '0, '0, 1'b1);
                else if (p < 1 || p > shadow_len)
                    push_result(pal_pkg::ST_BADPOS, '0, '0, 1'b1);
                else
                begin
                    removed = shadow_entries[p-1];
                    for (i = p; i < shadow_len; i++)
                        shadow_entries[i-1] = shadow_entries[i];
                    shadow_len--;
                    push_result(pal_pkg::ST_OK, removed, '0, 1'b1);
                end
            end
            pal_pkg::ACT_FIND:
            begin
                if (shadow_len == 0)
                    push_result(pal_pkg::ST_EMPTY, '0, '0, 1'b1);
                else
                begin
                    // First match wins
                    for (i = 0; i < shadow_len && hit == 0; i++)
                        if (shadow_entries[i] == val)
                            hit = i + 1;
                    if (hit != 0)
                        push_result(pal_pkg::ST_OK, '0, pal_pkg::POS_W'(hit), 1'b1);
                    else
                        push_result(pal_pkg::ST_NOTFOUND, '0, '0, 1'b1);
                end
            end
            pal_pkg::ACT_GET:
            begin
                if (p < 1 || p > shadow_len)
                    push_result(pal_pkg::ST_BADPOS, '0, '0, 1'b1);
                else
                    push_result(pal_pkg::ST_OK, shadow_entries[p-1], '0, 1'b1);
            end
            pal_pkg::ACT_DUMP:
            begin
                if (shadow_len == 0)
                    push_result(pal_pkg::ST_EMPTY, '0, '0, 1'b1);
                else
                    for (i = 0; i < shadow_len && i < pal_pkg::MAX_RESULTS; i++)
                        push_result(pal_pkg::ST_OK, shadow_entries[i], '0,
                                    (i + 1 == shadow_len || i + 1 == pal_pkg::MAX_RESULTS));
            end
            default:
                push_result(pal_pkg::ST_OK, '0, '0, 1'b1);
        endcase
    endfunction

    // Check every strobed result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        list_result_t exp_r;
        if (rst_n === 1'b1 && strobe === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result st=%0d data=%h fpos=%0d cnt=%0d last=%b",
                             $realtime, status, data_out, found_position, count, last);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (status !== exp_r.status || data_out !== exp_r.data ||
                    found_position !== exp_r.fpos || count !== exp_r.cnt ||
                    last !== exp_r.last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"%0t: mismatch exp st=%0d data=%h fpos=%0d cnt=%0d last=%b",
                                  " | got st=%0d data=%h fpos=%0d cnt=%0d last=%b"},
                                 $realtime, exp_r.status, exp_r.data, exp_r.fpos,
                                 exp_r.cnt, exp_r.last, status, data_out,
                                 found_position, count, last);
                end
            end
        end
    end

    // Send one request, idling first at the end of a burst; returns at the accepting edge
    task automatic send_request(input logic [pal_pkg::ACT_W-1:0] act,
                                input logic [pal_pkg::POS_W-1:0] pos,
                                input logic [pal_pkg::DATA_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        start    <= 1'b1;
        action   <= act;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predict_list_op(act, pos, val);
    endtask

    // Mostly a valid position in 1..hi, sometimes anything in 0..LIST_CAP
    function automatic logic [pal_pkg::POS_W-1:0] pick_position(int hi);
        if (hi >= 1 && $urandom_range(0, 4) != 0)
            return pal_pkg::POS_W'($urandom_range(1, hi));
        return pal_pkg::POS_W'($urandom_range(0, LIST_CAP));
    endfunction

    // Often an existing entry so that finds hit, sometimes an extreme
    function automatic logic [pal_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3 && shadow_len > 0)
            return shadow_entries[$urandom_range(0, shadow_len - 1)];
        if (r == 3)
            return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        return $urandom();
    endfunction

    // Every action but append on an empty list, plus the undefined codes
    task automatic test_empty_list();
        send_request(pal_pkg::ACT_DELETE, 7'd1, '0);
        send_request(pal_pkg::ACT_DELETE, 7'd0, '0);
        send_request(pal_pkg::ACT_FIND, 7'd0, VAL_MIN);
        send_request(pal_pkg::ACT_GET, 7'd1, '0);
        send_request(pal_pkg::ACT_GET, 7'd0, '0);
        send_request(pal_pkg::ACT_DUMP, 7'd0, '0);
        send_request(pal_pkg::ACT_INSERT, 7'd2, 32'h1234_5678);
        send_request(pal_pkg::ACT_INSERT, 7'd64, VAL_MAX);
        send_request(ACT_UNDEF_LO, 7'd64, VAL_MAX);
        send_request(ACT_UNDEF_HI, 7'd1, VAL_MIN);
    endtask

    // Value extremes, both insert ends, duplicate find, bad positions and a short dump
    task automatic test_basic_ops();
        send_request(pal_pkg::ACT_APPEND, 7'd0, VAL_MIN);
        send_request(pal_pkg::ACT_APPEND, 7'd64, VAL_MAX);
        send_request(pal_pkg::ACT_INSERT, 7'd1, 32'h0000_0000);
        send_request(pal_pkg::ACT_INSERT, 7'd4, 32'hFFFF_FFFF);
        send_request(pal_pkg::ACT_INSERT, 7'd2, 32'h5A5A_A5A5);
        send_request(pal_pkg::ACT_APPEND, 7'd0, 32'h0000_0000);
        send_request(pal_pkg::ACT_FIND, 7'd0, 32'h0000_0000);
        send_request(pal_pkg::ACT_FIND, 7'd0, 32'hFFFF_FFFF);
        send_request(pal_pkg::ACT_FIND, 7'd0, 32'h0001_E240);
        send_request(pal_pkg::ACT_GET, 7'd1, '0);
        send_request(pal_pkg::ACT_GET, 7'd6, '0);
        send_request(pal_pkg::ACT_GET, 7'd7, '0);
        send_request(pal_pkg::ACT_DELETE, 7'd64, '0);
        send_request(pal_pkg::ACT_DELETE, 7'd3, '0);
        send_request(pal_pkg::ACT_DELETE, 7'd5, '0);
        send_request(pal_pkg::ACT_DUMP, 7'd0, '0);
    endtask

    // Fill to capacity with random content, then hit the full cases and a full dump
    task automatic test_full_list();
        while (shadow_len < LIST_CAP)
        begin
            if ($urandom_range(0, 1))
                send_request(pal_pkg::ACT_APPEND, pal_pkg::POS_W'($urandom_range(0, LIST_CAP)),
                             pick_value());
            else
                send_request(pal_pkg::ACT_INSERT,
                             pal_pkg::POS_W'($urandom_range(1, shadow_len + 1)), pick_value());
        end
        send_request(pal_pkg::ACT_APPEND, 7'd0, $urandom());
        send_request(pal_pkg::ACT_INSERT, 7'd0, $urandom());
        send_request(pal_pkg::ACT_INSERT, 7'd1, $urandom());
        send_request(pal_pkg::ACT_FIND, 7'd0, shadow_entries[LIST_CAP - 1]);
        send_request(pal_pkg::ACT_FIND, 7'd0, $urandom());
        send_request(pal_pkg::ACT_GET, 7'd64, '0);
        send_request(pal_pkg::ACT_DUMP, 7'd0, '0);
        send_request(pal_pkg::ACT_DELETE, 7'd64, '0);
        send_request(pal_pkg::ACT_INSERT, 7'd64, VAL_MIN);
        send_request(pal_pkg::ACT_DELETE, 7'd1, '0);
    endtask

    // Random mix of all actions; the first stretch runs without sender gaps
    task automatic test_random_mix();
        int n;
        int r;
        for (n = 0; n < MIX_REQUESTS; n++)
        begin
            sender_gaps = (n >= 30);
            r = $urandom_range(0, 99);
            if (r < 15)
                send_request(pal_pkg::ACT_APPEND, pal_pkg::POS_W'($urandom_range(0, LIST_CAP)),
                             pick_value());
            else if (r < 30)
                send_request(pal_pkg::ACT_INSERT, pick_position(shadow_len + 1), pick_value());
            else if (r < 58)
                send_request(pal_pkg::ACT_DELETE, pick_position(shadow_len), $urandom());
            else if (r < 74)
                send_request(pal_pkg::ACT_FIND, pal_pkg::POS_W'($urandom_range(0, LIST_CAP)),
                             pick_value());
            else if (r < 90)
                send_request(pal_pkg::ACT_GET, pick_position(shadow_len), $urandom());
            else if (r < 97)
                send_request(pal_pkg::ACT_DUMP, pal_pkg::POS_W'($urandom_range(0, LIST_CAP)),
                             $urandom());
            else
                send_request($urandom_range(0, 1) ? ACT_UNDEF_LO : ACT_UNDEF_HI,
                             pal_pkg::POS_W'($urandom_range(0, LIST_CAP)), $urandom());
        end
        sender_gaps = 1'b1;
    endtask

    // Delete at random positions until empty, then probe the empty list again
    task automatic test_drain();
        while (shadow_len > 0)
            send_request(pal_pkg::ACT_DELETE, pal_pkg::POS_W'($urandom_range(1, shadow_len)),
                         $urandom());
        send_request(pal_pkg::ACT_DELETE, 7'd1, '0);
        send_request(pal_pkg::ACT_DUMP, 7'd0, '0);
        send_request(pal_pkg::ACT_FIND, 7'd0, '0);
    endtask

    initial
    begin : main
        rst_n    = 1'b0;
        start    = 1'b0;
        action   = '0;
        position = '0;
        value    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_random_mix();
        test_drain();

        // Drop start, wait for the last results, then allow stray strobes to show up
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
